// ----- hw/rtl/lis_pkg.sv -----
// shared types and constants for the longest increasing subsequence length unit
`default_nettype none

package lis_pkg;

   localparam int VALUE_W     = 32;
   localparam int OUT_LEN_W   = 9;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 24;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_STORE,
      S_RESULT
   } state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/longest_increasing_subsequence_length_unit.sv -----
// top level: sequencer, element store and result register of the lis length unit
//
// Streams signed 32-bit values in on the req_ channel (req_tdata = value, req_tlast marks
// the final element of a sequence) and returns one result per request on the rsp_ channel.
// rsp_tdata holds end_length, best_length and the overflow flag; rsp_tlast copies the
// request's last flag, and best_length is then the answer for the whole sequence.
// Each request scans every element stored so far through one shared compare unit, one
// ram read per cycle, is then stored and its result loaded into the result register; the
// next request is taken the cycle after the result is loaded, so no new request is taken
// while one is still in progress.
// A request beyond DEPTH elements is not stored or scanned; it goes straight to the result
// step and sets the overflow flag.
// The result register lets one finished result wait while the next request is taken and
// scanned; a stalled receiver holds the sequencer only when a second result is ready.
// Reset (synchronous, active high) empties the sequence and the result register; the
// store needs no clearing, since only entries written in the current sequence are read.
// After a request with req_tlast set the sequence state clears for the next sequence.
`default_nettype none

module longest_increasing_subsequence_length_unit #(
   parameter int DEPTH = 256
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // req_tdata: [31:0] value
   input  wire logic [lis_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                         req_tlast,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // rsp_tdata: [8:0] end_length, [17:9] best_length, [18] overflow, [23:19] zero
   output logic [lis_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready
);

   localparam int LEN_W = $clog2(DEPTH + 1);
   localparam int AW    = $clog2(DEPTH);
   localparam int MEM_W = lis_pkg::VALUE_W + LEN_W;

   lis_pkg::state_type state_ff, state_in;

   logic [LEN_W-1:0]            count_ff, count_in;
   logic [LEN_W-1:0]            idx_ff, idx_in;
   logic [LEN_W-1:0]            len_ff, len_in;
   logic [LEN_W-1:0]            best_ff, best_in;
   logic                        ovf_ff, ovf_in;
   logic [lis_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                        last_ff, last_in;
   logic                        rd_pend_ff, rd_pend_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [lis_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        wr_en;
   logic                        rd_en;
   logic [MEM_W-1:0]            wr_data;
   logic [MEM_W-1:0]            rd_data;
   logic [LEN_W-1:0]            cmp_len;
   logic [LEN_W+lis_pkg::OUT_LEN_W-1:0] end_ext;
   logic [LEN_W+lis_pkg::OUT_LEN_W-1:0] best_ext;

   assign wr_data = {value_ff, len_ff};

   lis_ram #(
      .WIDTH (MEM_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   lis_cmp #(
      .LEN_W (LEN_W)
   ) u_cmp (
      .stored_value (rd_data[MEM_W-1:LEN_W]),
      .stored_len   (rd_data[LEN_W-1:0]),
      .cand_value   (value_ff),
      .cur_len      (len_ff),
      .next_len     (cmp_len)
   );

   // lengths are truncated to the 9-bit result fields
   assign end_ext  = {{lis_pkg::OUT_LEN_W{1'b0}}, len_ff};
   assign best_ext = {{lis_pkg::OUT_LEN_W{1'b0}}, best_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lis_pkg::S_IDLE;
         count_ff     <= '0;
         best_ff      <= LEN_W'(1);
         ovf_ff       <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         best_ff      <= best_in;
         ovf_ff       <= ovf_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      len_ff      <= len_in;
      value_ff    <= value_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      len_in       = len_ff;
      best_in      = best_ff;
      ovf_in       = ovf_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      rd_pend_in   = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      case (state_ff)
         lis_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               value_in = req_tdata[lis_pkg::VALUE_W-1:0];
               last_in  = req_tlast;
               len_in   = LEN_W'(1);
               idx_in   = '0;
               if (count_ff < LEN_W'(DEPTH)) begin
                  state_in = lis_pkg::S_SCAN;
               end else begin
                  ovf_in   = 1'b1;
                  state_in = lis_pkg::S_RESULT;
               end
            end
         end
         lis_pkg::S_SCAN: begin
            // one read issued per cycle, folded in the cycle after
            if (idx_ff != count_ff) begin
               rd_en      = 1'b1;
               rd_pend_in = 1'b1;
               idx_in     = idx_ff + LEN_W'(1);
            end
            if (rd_pend_ff) begin
               len_in = cmp_len;
            end
            if ((idx_ff == count_ff) && !rd_pend_ff) begin
               state_in = lis_pkg::S_STORE;
            end
         end
         lis_pkg::S_STORE: begin
            wr_en    = 1'b1;
            count_in = count_ff + LEN_W'(1);
            if (len_ff > best_ff) begin
               best_in = len_ff;
            end
            state_in = lis_pkg::S_RESULT;
         end
         lis_pkg::S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = last_ff;
               rsp_data_in  = {5'b0, ovf_ff, best_ext[lis_pkg::OUT_LEN_W-1:0],
                               end_ext[lis_pkg::OUT_LEN_W-1:0]};
               if (last_ff) begin
                  count_in = '0;
                  best_in  = LEN_W'(1);
                  ovf_in   = 1'b0;
               end
               state_in = lis_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lis_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= LEN_W'(DEPTH))
      else $error("element count beyond depth");

   a_best_nonzero : assert property (@(posedge clock) disable iff (reset)
      (best_ff != '0) && (best_ff <= LEN_W'(DEPTH)))
      else $error("running best out of range");

   a_scan_index : assert property (@(posedge clock) disable iff (reset)
      (state_ff == lis_pkg::S_SCAN) |-> (idx_ff <= count_ff))
      else $error("scan index ran past stored elements");

   a_write_room : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff < LEN_W'(DEPTH)) && !rd_en)
      else $error("store write without room or during a read");

   a_one_at_a_time : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another is in progress");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/lis_ram.sv -----
// generic single-port-write, registered-read ram
`default_nettype none

module lis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/lis_cmp.sv -----
// shared compare and increment step: folds one stored element into the running length
`default_nettype none

module lis_cmp #(
   parameter int LEN_W = 9
) (
   input  wire logic [lis_pkg::VALUE_W-1:0] stored_value,
   input  wire logic [LEN_W-1:0]            stored_len,
   input  wire logic [lis_pkg::VALUE_W-1:0] cand_value,
   input  wire logic [LEN_W-1:0]            cur_len,
   output logic      [LEN_W-1:0]            next_len
);

   logic             smaller;
   logic [LEN_W-1:0] ext_len;

   always_comb begin
      smaller  = $signed(stored_value) < $signed(cand_value);
      ext_len  = stored_len + LEN_W'(1);
      next_len = (smaller && (ext_len > cur_len)) ? ext_len : cur_len;
   end

endmodule

`default_nettype wire
